[rtl/core/dltq_pkg.sv]
// Package for the delta-list timeout queue.
// Holds default sizes, mode and event codes and the controller state type.
// No dependencies.
package dltq_pkg;

  localparam int unsigned MaxEntriesDef = 8;
  localparam int unsigned DeltaBitsDef  = 32;
  localparam int unsigned IdBitsDef     = 8;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_ADD    = 3'd1,
    MODE_CANCEL = 3'd2,
    MODE_START  = 3'd3,
    MODE_ABORT  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    KIND_ACK     = 3'd0,
    KIND_EXPIRED = 3'd1,
    KIND_STOPPED = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_EMPTY   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_APPEND,
    ST_FIN
  } state_e;

endpackage

[rtl/core/dltq_store.sv]
// Ping-pong entry store for the delta-list timeout queue.
// Two banks, one registered read port and one write port; depends on nothing.
module dltq_store #(
  parameter int unsigned Depth = 8,
  parameter int unsigned Width = 40,
  parameter int unsigned AddrW = 3
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic             rd_bank_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic             wr_bank_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] bank0_q [Depth];
  logic [Width-1:0] bank1_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_bank_i) begin
      bank0_q[wr_addr_i] <= wr_data_i;
    end
    if (wr_en_i && wr_bank_i) begin
      bank1_q[wr_addr_i] <= wr_data_i;
    end
  end

  // hold the read data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= rd_bank_i ? bank1_q[rd_addr_i] : bank0_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/delta_list_timeout_queue.sv]
// Delta-list timeout queue, top level.
// Depends on dltq_pkg and dltq_store.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command per transfer:
//   mode_i (tick, add, cancel, start, abort), duration_ticks_i, instrument_id_i.
//   Output channel (out_valid_o/out_ready_i) carries event_kind_o, event_id_o
//   and last_of_run_o. Every command yields one or more events; the final one
//   has last_of_run_o set. Commands are taken one at a time.
// Timing:
//   A command is taken in idle and decoded in the next cycle, then walks the list
//   at one stored entry per cycle while the output does not stall (add revisits
//   one entry to split the successor's delta, or appends at the tail in a
//   separate state), and finishes in a state that hands over the last event.
// Reset:
//   The list is empty and stopped after reset; no clearing pass is needed.
// Stall:
//   One event waits in the output register and one more is held back inside;
//   when both are occupied and the receiver stalls, the walk pauses in place.
module delta_list_timeout_queue
  import dltq_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  parameter int unsigned DELTA_BITS  = DeltaBitsDef,
  parameter int unsigned ID_BITS     = IdBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [31:0] duration_ticks_i,
  input  logic [7:0]  instrument_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_kind_o,
  output logic [7:0]  event_id_o,
  output logic        last_of_run_o
);

  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IdxW  = $clog2(MAX_ENTRIES);
  localparam int unsigned CumW  = DELTA_BITS + CntW;
  localparam int unsigned EntW  = DELTA_BITS + ID_BITS;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                running_q, running_d;
  logic                bank_q, bank_d;
  logic [CntW-1:0]     r_q, r_d;
  logic [CntW-1:0]     w_q, w_d;
  logic [2:0]          mode_q, mode_d;
  logic [DELTA_BITS-1:0] dur_q, dur_d;
  logic [ID_BITS-1:0]  id_q, id_d;
  logic                popping_q, popping_d;
  logic                placed_q, placed_d;
  logic                fix_q, fix_d;
  logic [CumW-1:0]     cum_q, cum_d;
  logic [DELTA_BITS-1:0] carry_q, carry_d;
  logic                pend_valid_q, pend_valid_d;
  kind_e               pend_kind_q, pend_kind_d;
  logic [ID_BITS-1:0]  pend_id_q, pend_id_d;
  logic                out_valid_q, out_valid_d;
  logic [2:0]          out_kind_q, out_kind_d;
  logic [7:0]          out_id_q, out_id_d;
  logic                out_last_q, out_last_d;

  // store interface
  logic                rd_en, wr_en;
  logic [IdxW-1:0]     rd_addr;
  logic [EntW-1:0]     rd_data;
  logic [DELTA_BITS-1:0] rd_delta, wr_delta, eff_delta;
  logic [ID_BITS-1:0]  rd_owner, wr_owner;

  // walk helpers
  logic                out_free, emit_req, blocked, advance, wr_ent;
  kind_e               emit_kind;
  logic [ID_BITS-1:0]  emit_id;
  logic [CumW-1:0]     next_cum, dur_w;
  logic [CntW-1:0]     r_next, w_after;

  dltq_store #(
    .Depth (MAX_ENTRIES),
    .Width (EntW),
    .AddrW (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_bank_i (bank_q),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_bank_i (~bank_q),
    .wr_addr_i (w_q[IdxW-1:0]),
    .wr_data_i ({wr_delta, wr_owner}),
    .rd_data_o (rd_data)
  );

  assign rd_delta  = rd_data[EntW-1:ID_BITS];
  assign rd_owner  = rd_data[ID_BITS-1:0];
  // only the head counts down on a tick
  assign eff_delta = (r_q == '0 && rd_delta != '0) ? rd_delta - 1'b1 : rd_delta;
  assign next_cum  = cum_q + CumW'(rd_delta);
  assign dur_w     = CumW'(dur_q);
  assign r_next    = r_q + 1'b1;
  assign out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      running_q    <= 1'b0;
      bank_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      running_q    <= running_d;
      bank_q       <= bank_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q         <= r_d;
    w_q         <= w_d;
    mode_q      <= mode_d;
    dur_q       <= dur_d;
    id_q        <= id_d;
    popping_q   <= popping_d;
    placed_q    <= placed_d;
    fix_q       <= fix_d;
    cum_q       <= cum_d;
    carry_q     <= carry_d;
    pend_kind_q <= pend_kind_d;
    pend_id_q   <= pend_id_d;
    out_kind_q  <= out_kind_d;
    out_id_q    <= out_id_d;
    out_last_q  <= out_last_d;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    running_d    = running_q;
    bank_d       = bank_q;
    r_d          = r_q;
    w_d          = w_q;
    mode_d       = mode_q;
    dur_d        = dur_q;
    id_d         = id_q;
    popping_d    = popping_q;
    placed_d     = placed_q;
    fix_d        = fix_q;
    cum_d        = cum_q;
    carry_d      = carry_q;
    pend_valid_d = pend_valid_q;
    pend_kind_d  = pend_kind_q;
    pend_id_d    = pend_id_q;
    out_valid_d  = out_valid_q;
    out_kind_d   = out_kind_q;
    out_id_d     = out_id_q;
    out_last_d   = out_last_q;
    in_ready_o   = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = r_q[IdxW-1:0];
    wr_en        = 1'b0;
    wr_delta     = '0;
    wr_owner     = '0;
    emit_req     = 1'b0;
    emit_kind    = KIND_ACK;
    emit_id      = '0;
    advance      = 1'b0;
    wr_ent       = 1'b0;
    blocked      = 1'b0;
    w_after      = w_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d  = mode_i;
          dur_d   = DELTA_BITS'(duration_ticks_i);
          id_d    = ID_BITS'(instrument_id_i);
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        r_d       = '0;
        w_d       = '0;
        popping_d = 1'b1;
        placed_d  = 1'b0;
        fix_d     = 1'b0;
        cum_d     = '0;
        carry_d   = '0;
        state_d   = ST_FIN;
        rd_addr   = '0;
        case (mode_q)
          MODE_TICK: begin
            if (running_q && count_q != '0) begin
              rd_en   = 1'b1;
              state_d = ST_WALK;
            end
          end
          MODE_ADD: begin
            if (count_q >= CntW'(MAX_ENTRIES)) begin
              pend_valid_d = 1'b1;
              pend_kind_d  = KIND_FULL;
              pend_id_d    = '0;
            end else if (count_q == '0) begin
              state_d = ST_APPEND;
            end else begin
              rd_en   = 1'b1;
              state_d = ST_WALK;
            end
          end
          MODE_CANCEL, MODE_ABORT: begin
            if (count_q != '0) begin
              rd_en   = 1'b1;
              state_d = ST_WALK;
            end
          end
          MODE_START: begin
            if (!running_q) begin
              if (count_q == '0) begin
                pend_valid_d = 1'b1;
                pend_kind_d  = KIND_EMPTY;
                pend_id_d    = '0;
              end else begin
                running_d = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end

      ST_WALK: begin
        case (mode_q)
          MODE_TICK: begin
            advance = 1'b1;
            if (popping_q && eff_delta == '0) begin
              emit_req  = 1'b1;
              emit_kind = KIND_EXPIRED;
              emit_id   = rd_owner;
            end else begin
              popping_d = 1'b0;
              wr_ent    = 1'b1;
              wr_delta  = eff_delta;
              wr_owner  = rd_owner;
            end
          end
          MODE_ADD: begin
            wr_ent = 1'b1;
            if (!placed_q && dur_w <= next_cum) begin
              // new entry goes first; revisit this entry to split its delta
              wr_delta = DELTA_BITS'(dur_w - cum_q);
              wr_owner = id_q;
              placed_d = 1'b1;
              fix_d    = 1'b1;
            end else if (fix_q) begin
              wr_delta = DELTA_BITS'(next_cum - dur_w);
              wr_owner = rd_owner;
              fix_d    = 1'b0;
              advance  = 1'b1;
            end else begin
              wr_delta = rd_delta;
              wr_owner = rd_owner;
              advance  = 1'b1;
              if (!placed_q) begin
                cum_d = next_cum;
              end
            end
          end
          MODE_CANCEL: begin
            advance = 1'b1;
            if (rd_owner == id_q) begin
              carry_d = carry_q + rd_delta;
            end else begin
              wr_ent   = 1'b1;
              wr_delta = rd_delta + carry_q;
              wr_owner = rd_owner;
              carry_d  = '0;
            end
          end
          default: begin
            // abort: report every entry, write nothing back
            advance   = 1'b1;
            emit_req  = 1'b1;
            emit_kind = KIND_STOPPED;
            emit_id   = rd_owner;
          end
        endcase

        blocked = emit_req && pend_valid_q && !out_free;

        if (blocked) begin
          // hold everything; read data stays put
          popping_d = popping_q;
        end else begin
          if (emit_req) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_kind_d  = pend_kind_q;
              out_id_d    = 8'(pend_id_q);
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_kind_d  = emit_kind;
            pend_id_d    = emit_id;
          end
          if (wr_ent) begin
            wr_en   = 1'b1;
            w_after = w_q + 1'b1;
            w_d     = w_after;
          end
          if (advance) begin
            r_d = r_next;
            if (r_next == count_q) begin
              state_d = ST_FIN;
              case (mode_q)
                MODE_ABORT: begin
                  count_d   = '0;
                  running_d = 1'b0;
                end
                MODE_ADD: begin
                  if (!placed_d) begin
                    state_d = ST_APPEND;
                  end else begin
                    count_d = w_after;
                    bank_d  = ~bank_q;
                  end
                end
                default: begin
                  count_d = w_after;
                  bank_d  = ~bank_q;
                  if (w_after == '0) begin
                    running_d = 1'b0;
                  end
                end
              endcase
            end else begin
              rd_en   = 1'b1;
              rd_addr = r_next[IdxW-1:0];
            end
          end
        end
      end

      ST_APPEND: begin
        // new entry lands at the tail
        wr_en    = 1'b1;
        wr_delta = DELTA_BITS'(dur_w - cum_q);
        wr_owner = id_q;
        count_d  = w_q + 1'b1;
        bank_d   = ~bank_q;
        state_d  = ST_FIN;
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = pend_valid_q ? pend_kind_q : KIND_ACK;
          out_id_d     = pend_valid_q ? 8'(pend_id_q) : 8'd0;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = out_kind_q;
  assign event_id_o    = out_id_q;
  assign last_of_run_o = out_last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_running_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> count_q != '0)
    else $error("running with an empty list");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_valid_q)
    else $error("held-back event left over at idle");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> r_q < count_q)
    else $error("walk index past the list end");
`endif

endmodule
